// ===== design/salc_pkg.sv =====
// Shared constants, types and helpers for the set-associative LRU cache lookup.
// Used by salc_ctrl, salc_dp and the top level set_assoc_lru_cache_lookup.
package salc_pkg;

  function automatic int floor_log2(input int v);
    int b;
    int x;
    b = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      b = b + 1;
    end
    return b;
  endfunction

  localparam int LINE_BYTES = 16;
  localparam int WAYS       = 4;
  localparam int SETS       = 2;

  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 32;
  localparam int TAG_W    = 27;
  localparam int OFF_BITS = floor_log2(LINE_BYTES);
  localparam int SET_BITS = floor_log2(SETS);
  localparam int SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_LSB  = OFF_BITS + SET_BITS;

  typedef logic [TAG_W-1:0]              tag_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]    tag_row_t;
  typedef logic [WAYS-1:0]               valid_row_t;
  typedef logic [SET_IW-1:0]             set_idx_t;
  typedef logic [COUNT_W-1:0]            count_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the input word and read its set
    logic commit;  // write back the reordered set, update counts and result
  } salc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } salc_state_t;

endpackage

// ===== design/salc_ctrl.sv =====
// Controller for the cache lookup: input/output handshakes and sequencing.
// Depends on salc_pkg for the state encoding and the command struct.
module salc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output salc_pkg::salc_cmd_t cmd
);
  import salc_pkg::*;

  salc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.commit = (state_r == ST_UPDATE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold while the previous result is still waiting
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_UPDATE))
    else $error("accepted word did not move to update");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed word produced no result");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) && out_valid_r && out_stall |=> (state_r == ST_UPDATE))
    else $error("update left while the result register was blocked");

  a_no_load_and_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.commit))
    else $error("load and commit in the same cycle");

endmodule

// ===== design/salc_dp.sv =====
// Datapath for the cache lookup: tag memory, valid bits, compare, LRU reorder, counts.
// Depends on salc_pkg; driven by salc_ctrl commands.
module salc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  salc_pkg::salc_cmd_t         cmd,
  input  logic [31:0]                 in_address,
  output logic                        out_hit,
  output logic                        out_set_index,
  output logic [31:0]                 out_hit_count,
  output logic [31:0]                 out_miss_count
);
  import salc_pkg::*;

  tag_row_t   tag_mem [SETS];
  valid_row_t valid_r [SETS];

  tag_row_t   rd_tags_r;
  valid_row_t rd_valid_r;
  set_idx_t   set_r;
  tag_t       tag_r;
  set_idx_t   in_set;

  count_t     hits_r, misses_r;
  logic       hit_r;
  set_idx_t   out_set_r;

  logic       found;
  logic [WAYS-1:0] past_hit;  // way lies beyond the matching way
  tag_row_t   new_tags;
  valid_row_t new_valid;

  always_comb begin
    if (SET_BITS == 0) begin
      in_set = '0;
    end else begin
      in_set = SET_IW'(in_address >> OFF_BITS);
    end
  end

  // Read the set at accept time so the compare runs in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_tags_r <= tag_mem[in_set];
      set_r     <= in_set;
      tag_r     <= TAG_W'(in_address >> TAG_LSB);
    end
    if (cmd.commit) begin
      tag_mem[set_r] <= new_tags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) valid_r[s] <= '0;
      rd_valid_r <= '0;
    end else begin
      if (cmd.load) rd_valid_r <= valid_r[in_set];
      if (cmd.commit) valid_r[set_r] <= new_valid;
    end
  end

  // First matching way; valid ways form a prefix so a match needs its valid bit
  always_comb begin
    found    = 1'b0;
    past_hit = '0;
    for (int i = 0; i < WAYS; i++) begin
      past_hit[i] = found;
      if (!found && rd_valid_r[i] && (rd_tags_r[i] == tag_r)) found = 1'b1;
    end
  end

  // Move to front: ways up to the match (all ways on a miss) shift back, ways past it stay
  always_comb begin
    new_tags     = rd_tags_r;
    new_valid    = rd_valid_r;
    new_tags[0]  = tag_r;
    new_valid[0] = 1'b1;
    for (int j = 1; j < WAYS; j++) begin
      if (!(found && past_hit[j])) begin
        new_tags[j]  = rd_tags_r[j-1];
        new_valid[j] = rd_valid_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.commit) begin
      if (found) begin
        if (hits_r != '1) hits_r <= hits_r + COUNT_W'(1);
      end else begin
        if (misses_r != '1) misses_r <= misses_r + COUNT_W'(1);
      end
    end
  end

  // Hold the result fields until the next commit, even while a new word loads
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r     <= found;
      out_set_r <= set_r;
    end
  end

  assign out_hit        = hit_r;
  assign out_set_index  = out_set_r[0];
  assign out_hit_count  = hits_r;
  assign out_miss_count = misses_r;

endmodule

// ===== design/set_assoc_lru_cache_lookup.sv =====
// Set-associative LRU cache lookup, top level.
// Joins the controller salc_ctrl and the datapath salc_dp; uses salc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_address): one byte address per word.
//   The address splits into line offset (dropped), set index and a 27-bit tag.
//   Output channel (out_valid / out_stall): hit flag, set index and the
//   saturating running hit and miss counts, counting this access.
//   Each accepted word has its set read and registered at accept; its result
//   is registered when its update cycle commits. The set is read from the tag
//   memory at the accept edge, compared and written back reordered when the
//   update commits; the next word is taken only once this one is written back.
//   in_stall is high while a word is in its update cycle.
//   When the receiver stalls, the result register holds; a following word is
//   still accepted and read, then waits in its update cycle until the
//   result register frees.
//   Reset (rst_n low, synchronous) clears all valid bits and both counts at
//   once; no clearing pass is needed, the block is ready the cycle after.
module set_assoc_lru_cache_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic        out_set_index,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count
);
  import salc_pkg::*;

  salc_cmd_t cmd;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  salc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_address     (in_address),
    .out_hit        (out_hit),
    .out_set_index  (out_set_index),
    .out_hit_count  (out_hit_count),
    .out_miss_count (out_miss_count)
  );

endmodule

// ===== verif/set_assoc_lru_cache_lookup_chk.sv =====
// Checker for set_assoc_lru_cache_lookup: watches both channels, predicts each result
// from an own LRU tag store and compares it field by field. Depends on salc_pkg.
`timescale 1ns / 100ps

module set_assoc_lru_cache_lookup_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_hit,
  input  logic        out_set_index,
  input  logic [31:0] out_hit_count,
  input  logic [31:0] out_miss_count,
  output int          mismatches,
  output int          outstanding
);
  import salc_pkg::*;

  typedef struct {
    bit     hit;
    bit     set_index;
    count_t hit_count;
    count_t miss_count;
  } lookup_result_t;

  localparam count_t COUNT_TOP = '1;

  tag_t           lru_tags  [SETS][WAYS];
  bit             lru_valid [SETS][WAYS];
  count_t         hits_seen;
  count_t         misses_seen;
  lookup_result_t expected_lookups[$];

  initial mismatches = 0;
  assign outstanding = expected_lookups.size();

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic lookup_result_t access_line(input logic [31:0] addr);
    lookup_result_t r;
    int unsigned    set_num;
    tag_t           tag;
    int             found;
    int             last;
    set_num = (addr >> OFF_BITS) & ((1 << SET_BITS) - 1);
    if (set_num >= SETS) set_num = SETS - 1;
    tag = tag_t'(addr >> TAG_LSB);
    found = -1;
    for (int w = 0; w < WAYS; w++) begin
      // an invalid way ends the search: valid ways form a prefix
      if (!lru_valid[set_num][w]) break;
      if (lru_tags[set_num][w] == tag) begin
        found = w;
        break;
      end
    end
    last = (found >= 0) ? found : WAYS - 1;
    for (int w = last; w > 0; w--) begin
      lru_tags[set_num][w]  = lru_tags[set_num][w-1];
      lru_valid[set_num][w] = lru_valid[set_num][w-1];
    end
    lru_tags[set_num][0]  = tag;
    lru_valid[set_num][0] = 1'b1;
    if (found >= 0) begin
      if (hits_seen != COUNT_TOP) hits_seen++;
    end else begin
      if (misses_seen != COUNT_TOP) misses_seen++;
    end
    r.hit        = (found >= 0);
    r.set_index  = set_num[0];
    r.hit_count  = hits_seen;
    r.miss_count = misses_seen;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lookup_result_t want;
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++)
        for (int w = 0; w < WAYS; w++) lru_valid[s][w] = 1'b0;
      hits_seen   = '0;
      misses_seen = '0;
      expected_lookups.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("result word with no access pending");
        end else begin
          want = expected_lookups.pop_front();
          if (out_hit !== want.hit)
            report_mismatch($sformatf("hit mismatch: got %0h, expected %0h",
                                      out_hit, want.hit));
          if (out_set_index !== want.set_index)
            report_mismatch($sformatf("set_index mismatch: got %0h, expected %0h",
                                      out_set_index, want.set_index));
          if (out_hit_count !== want.hit_count)
            report_mismatch($sformatf("hit_count mismatch: got %0h, expected %0h",
                                      out_hit_count, want.hit_count));
          if (out_miss_count !== want.miss_count)
            report_mismatch($sformatf("miss_count mismatch: got %0h, expected %0h",
                                      out_miss_count, want.miss_count));
        end
      end
      if (in_valid && !in_stall) expected_lookups.push_back(access_line(in_address));
    end
  end

endmodule

// ===== verif/set_assoc_lru_cache_lookup_tb.sv =====
// Top of the set_assoc_lru_cache_lookup testbench: clock, reset, address stimulus
// and receiver stalls. Depends on salc_pkg, the block and set_assoc_lru_cache_lookup_chk.
`timescale 1ns / 100ps

module set_assoc_lru_cache_lookup_tb;
  import salc_pkg::*;

  localparam int RANDOM_WORDS = 2000;
  localparam int CALM_WORDS   = 300;
  localparam int POOL_SIZE    = 6;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_address;
  logic        out_valid;
  logic        out_stall;
  logic        out_hit;
  logic        out_set_index;
  logic [31:0] out_hit_count;
  logic [31:0] out_miss_count;
  int          mismatches;
  int          outstanding;
  bit          calm;

  set_assoc_lru_cache_lookup u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_set_index  (out_set_index),
    .out_hit_count  (out_hit_count),
    .out_miss_count (out_miss_count)
  );

  set_assoc_lru_cache_lookup_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_set_index  (out_set_index),
    .out_hit_count  (out_hit_count),
    .out_miss_count (out_miss_count),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("set_assoc_lru_cache_lookup test failed");
    $finish;
  end

  // receiver stalls in short bursts until the calm tail
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [31:0] addr);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    // hold the word until the block takes it
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] line_address(input tag_t tag, input bit set_sel);
    logic [31:0] offset;
    offset = $urandom_range(0, LINE_BYTES - 1);
    return (32'(tag) << TAG_LSB) | (32'(set_sel) << OFF_BITS) | offset;
  endfunction

  initial begin
    logic [31:0] directed_words [] = '{
      // first touch of each set misses since reset clears the valid bits, not the tags
      32'h0000_0010, 32'h0000_0000, 32'h0000_000F,
      32'hFFFF_FFFF, 32'hFFFF_FFF0,
      // fill set 0, then hit the oldest way and a middle way
      32'h0000_0020, 32'h0000_0040, 32'h0000_0060,
      32'h0000_0000, 32'h0000_0040,
      // a fifth tag evicts the least recent one, which then misses
      32'h0000_0080, 32'h0000_0020, 32'h0000_0080,
      32'h0000_0018,
      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h8000_0000, 32'h7FFF_FFEF, 32'h8000_000C
    };
    tag_t tag_pool [POOL_SIZE];
    int   guard;

    calm       = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_address <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[i]) send_word(directed_words[i]);

    foreach (tag_pool[i]) tag_pool[i] = tag_t'($urandom);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      // swap out one pool tag now and then so lines age out of the sets
      if ($urandom_range(0, 15) == 0)
        tag_pool[$urandom_range(0, POOL_SIZE - 1)] = tag_t'($urandom);
      if ($urandom_range(0, 99) < 85)
        send_word(line_address(tag_pool[$urandom_range(0, POOL_SIZE - 1)],
                               1'($urandom_range(0, 1))));
      else
        send_word($urandom);
    end
    in_valid <= 1'b0;

    guard = 0;
    while (outstanding != 0 && guard < 500) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("set_assoc_lru_cache_lookup test passed");
    end else begin
      $display("set_assoc_lru_cache_lookup test failed");
    end
    $finish;
  end

endmodule
